@@ hdl/unicode_char_width_classifier_core_assert.svh @@
// assertion macros shared by the classifier rtl
`ifndef UNICODE_CHAR_WIDTH_CLASSIFIER_CORE_ASSERT_SVH
`define UNICODE_CHAR_WIDTH_CLASSIFIER_CORE_ASSERT_SVH

// consequent checked in the same cycle
`define UCWC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the following cycle
`define UCWC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/ucwc_pkg.sv @@
// types, constants and helper functions of the width classifier
`default_nettype none

package ucwc_pkg;

	// table geometry
	localparam int unsigned ZT_DEPTH = 512;
	localparam int unsigned WT_DEPTH = 256;
	localparam int unsigned ZT_AW = $clog2(ZT_DEPTH);
	localparam int unsigned WT_AW = $clog2(WT_DEPTH);
	localparam int unsigned SRCH_AW = (ZT_AW > WT_AW) ? ZT_AW : WT_AW;
	localparam int unsigned CNT_W = SRCH_AW + 1;
	localparam int unsigned IDX_W = SRCH_AW + 2;

	// field widths
	localparam int unsigned CP_W = 21;
	localparam int unsigned OP_W = 2;
	localparam int unsigned EIDX_W = 9;
	localparam int unsigned CW_W = 3;
	localparam int unsigned SUM_W = 16;
	localparam int unsigned ZC_W = 10;
	localparam int unsigned WC_W = 9;
	localparam int unsigned CFG_AW = 2;
	localparam int unsigned CFG_DW = 10;

	// operation codes
	localparam logic [OP_W-1:0] OP_CLASSIFY = 2'd0;
	localparam logic [OP_W-1:0] OP_LOAD_ZERO = 2'd1;
	localparam logic [OP_W-1:0] OP_LOAD_WIDE = 2'd2;

	// configuration register indexes
	localparam logic [CFG_AW-1:0] CFG_ZERO_COUNT = 2'd0;
	localparam logic [CFG_AW-1:0] CFG_WIDE_COUNT = 2'd1;
	localparam logic [CFG_AW-1:0] CFG_CONTROL_WIDTH = 2'd2;

	localparam logic signed [CW_W-1:0] CTRL_W_RESET = -3'sd1;

	// fixed code points
	localparam logic [CP_W-1:0] CP_CGJ = 21'h00034F;
	localparam logic [CP_W-1:0] CP_ZWSP = 21'h00200B;
	localparam logic [CP_W-1:0] CP_RLM = 21'h00200F;
	localparam logic [CP_W-1:0] CP_LSEP = 21'h002028;
	localparam logic [CP_W-1:0] CP_PSEP = 21'h002029;
	localparam logic [CP_W-1:0] CP_LRE = 21'h00202A;
	localparam logic [CP_W-1:0] CP_RLO = 21'h00202E;
	localparam logic [CP_W-1:0] CP_WJ = 21'h002060;
	localparam logic [CP_W-1:0] CP_ISEP = 21'h002063;
	localparam logic [CP_W-1:0] CP_DEL = 21'h00007F;
	localparam logic [CP_W-1:0] CP_NBSP = 21'h0000A0;
	localparam logic [CP_W-1:0] CP_SPACE = 21'h000020;

	// one stored interval, inclusive bounds
	typedef struct packed {
		logic [CP_W-1:0] first;
		logic [CP_W-1:0] last;
	} ival_t;

	localparam int unsigned ENT_W = $bits(ival_t);

	// search request and result between top and search engines
	typedef struct packed {
		logic             start;
		logic [CNT_W-1:0] cnt;
		logic [CP_W-1:0]  cp;
	} srch_req_t;

	typedef struct packed {
		logic done;
		logic hit;
	} srch_res_t;

	typedef enum logic [1:0] {
		SR_IDLE,
		SR_FIRST,
		SR_PROBE
	} srch_st_t;

	typedef enum logic [1:0] {
		TS_IDLE,
		TS_START,
		TS_WAIT
	} top_st_t;

	typedef enum logic [1:0] {
		CL_FIXED_ZERO,
		CL_CONTROL,
		CL_SEARCH
	} cls_t;

	// format characters and nul that are always zero width
	function automatic logic fixed_zero(input logic [CP_W-1:0] cp);
		fixed_zero = (cp == '0) || (cp == CP_CGJ) ||
			(cp >= CP_ZWSP && cp <= CP_RLM) ||
			(cp == CP_LSEP) || (cp == CP_PSEP) ||
			(cp >= CP_LRE && cp <= CP_RLO) ||
			(cp >= CP_WJ && cp <= CP_ISEP);
	endfunction

	// c0 and c1 controls
	function automatic logic is_ctrl(input logic [CP_W-1:0] cp);
		is_ctrl = (cp < CP_SPACE) || (cp >= CP_DEL && cp < CP_NBSP);
	endfunction

endpackage

`default_nettype wire

@@ hdl/ucwc_chan_if.sv @@
// handshake channel interfaces: input items, results, configuration writes
`default_nettype none

interface ucwc_in_if
	import ucwc_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   op;
	logic [EIDX_W-1:0] entry_index;
	logic [CP_W-1:0]   range_first;
	logic [CP_W-1:0]   range_last;
	logic [CP_W-1:0]   code_point;
	logic              end_of_string;

	modport source (
		output valid, op, entry_index, range_first, range_last, code_point, end_of_string,
		input  ready
	);
	modport sink (
		input  valid, op, entry_index, range_first, range_last, code_point, end_of_string,
		output ready
	);
endinterface

interface ucwc_out_if
	import ucwc_pkg::*;
();
	logic                   valid;
	logic                   ready;
	logic signed [CW_W-1:0] char_width;
	logic                   is_control;
	logic [SUM_W-1:0]       string_width;
	logic                   string_invalid;
	logic                   string_done;

	modport source (
		output valid, char_width, is_control, string_width, string_invalid, string_done,
		input  ready
	);
	modport sink (
		input  valid, char_width, is_control, string_width, string_invalid, string_done,
		output ready
	);
endinterface

interface ucwc_cfg_if
	import ucwc_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [CFG_AW-1:0] index;
	logic [CFG_DW-1:0] data;

	modport source (
		output valid, index, data,
		input  ready
	);
	modport sink (
		input  valid, index, data,
		output ready
	);
endinterface

`default_nettype wire

@@ hdl/ucwc_ram.sv @@
// simple dual-port ram, one write and one registered read port
`default_nettype none

module ucwc_ram #(
	parameter int unsigned DEPTH = 512,
	parameter int unsigned WIDTH = 42
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ hdl/ucwc_search.sv @@
// binary search engine over one interval ram
`default_nettype none
`include "unicode_char_width_classifier_core_assert.svh"

module ucwc_search
	import ucwc_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire srch_req_t          req,
	input  wire logic [ENT_W-1:0]   rd_data,
	output logic      [SRCH_AW-1:0] rd_addr,
	output srch_res_t               res
);

	srch_st_t                 state_q, state_d;
	srch_res_t                res_q, res_d;
	logic [CNT_W-1:0]         cnt_q;
	logic [CP_W-1:0]          cp_q;
	logic signed [IDX_W-1:0]  bot_q, top_q, bot_n, top_n, mid_s;
	logic signed [IDX_W:0]    mid_sum;
	logic [SRCH_AW-1:0]       mid_q, mid_n;
	ival_t                    ent;
	logic                     below_first, above_last, hit, empty;

	// compare the entry that came back from the ram
	always_comb begin
		ent = ival_t'(rd_data);
		below_first = cp_q < ent.first;
		above_last = ent.last < cp_q;
		hit = 1'b0;
		mid_s = $signed(IDX_W'(mid_q));
		bot_n = bot_q;
		top_n = top_q;
		case (state_q)
			SR_FIRST: begin
				bot_n = '0;
				top_n = $signed(IDX_W'(cnt_q)) - $signed(IDX_W'(1));
			end
			SR_PROBE: begin
				if (above_last) begin
					bot_n = mid_s + $signed(IDX_W'(1));
				end else if (below_first) begin
					top_n = mid_s - $signed(IDX_W'(1));
				end else begin
					hit = 1'b1;
				end
			end
			default: ;
		endcase
		empty = top_n < bot_n;
		mid_sum = (IDX_W+1)'(bot_n) + (IDX_W+1)'(top_n);
		mid_n = mid_sum[SRCH_AW:1];
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SR_IDLE: begin
				if (req.start && req.cnt != '0) begin
					state_d = SR_FIRST;
				end
			end
			SR_FIRST: begin
				state_d = below_first ? SR_IDLE : SR_PROBE;
			end
			SR_PROBE: begin
				if (hit || empty) begin
					state_d = SR_IDLE;
				end
			end
			default: state_d = SR_IDLE;
		endcase
	end

	// read address and completion
	always_comb begin
		rd_addr = '0;
		res_d = '0;
		unique case (state_q)
			SR_IDLE: begin
				res_d.done = req.start && req.cnt == '0;
			end
			SR_FIRST: begin
				rd_addr = mid_n;
				res_d.done = below_first;
			end
			SR_PROBE: begin
				rd_addr = mid_n;
				res_d.done = hit || empty;
				res_d.hit = hit;
			end
			default: ;
		endcase
	end

	assign res = res_q;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SR_IDLE;
			res_q <= '0;
		end else begin
			state_q <= state_d;
			res_q <= res_d;
		end
	end

	// search bounds and latched request
	always_ff @(posedge clk) begin
		if (state_q == SR_IDLE && req.start) begin
			cnt_q <= req.cnt;
			cp_q <= req.cp;
		end
		bot_q <= bot_n;
		top_q <= top_n;
		mid_q <= mid_n;
	end

	`UCWC_ASSERT_SAME(a_start_idle, req.start, state_q == SR_IDLE, "search started while busy")
	`UCWC_ASSERT_SAME(a_probe_range, state_q == SR_PROBE, CNT_W'(mid_q) < cnt_q, "probe beyond count")
	`UCWC_ASSERT_SAME(a_done_idle, res_q.done, state_q == SR_IDLE, "done while still searching")

endmodule

`default_nettype wire

@@ hdl/unicode_char_width_classifier_core.sv @@
// top level: terminal column width classifier with loadable interval tables
//
//   channel  dir   fields
//   item     in    op, entry_index, range_first, range_last, code_point, end_of_string
//   result   out   char_width, is_control, string_width, string_invalid, string_done
//   cfg      in    index, data (zero_count, wide_count, control_width)
//
// a table load goes straight to its ram; a classify starts both searches, one ram read
// per probe, and ends once both are done and the output register is free.
// both tables are searched at the same time, each with its own ram read port.
// the tables have no reset and no clearing pass; counts, sums and flags reset at once.
// a finished result sits in the output register; the next transaction is taken meanwhile.
`default_nettype none
`include "unicode_char_width_classifier_core_assert.svh"

module unicode_char_width_classifier_core
	import ucwc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	ucwc_in_if.sink   item,
	ucwc_out_if.source result,
	ucwc_cfg_if.sink  cfg
);

	top_st_t                state_q, state_d;
	logic [ZC_W-1:0]        zero_cnt_q;
	logic [WC_W-1:0]        wide_cnt_q;
	logic signed [CW_W-1:0] ctrl_w_q;
	logic [CNT_W-1:0]       zt_cnt, wt_cnt;
	logic                   acc, zt_we, wt_we;
	logic [CP_W-1:0]        cp_q;
	logic                   eos_q;
	cls_t                   cls_q;
	srch_req_t              zreq, wreq;
	srch_res_t              zres, wres;
	logic [SRCH_AW-1:0]     z_addr, w_addr;
	logic [ENT_W-1:0]       z_data, w_data;
	logic                   z_seen_q, w_seen_q, z_hit_q, w_hit_q;
	logic                   z_fin, w_fin, z_hit, w_hit;
	logic                   slot_free, finish, start;
	logic signed [CW_W-1:0] w;
	logic [SUM_W:0]         sum_ext;
	logic [SUM_W-1:0]       sum_new, width_sum_q;
	logic                   inv_new, invalid_q;
	logic                   out_valid_q;
	logic signed [CW_W-1:0] out_w_q;
	logic                   out_ctrl_q, out_inv_q, out_done_q;
	logic [SUM_W-1:0]       out_sum_q;

	// configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_cnt_q <= '0;
			wide_cnt_q <= '0;
			ctrl_w_q <= CTRL_W_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_ZERO_COUNT: zero_cnt_q <= cfg.data[ZC_W-1:0];
				CFG_WIDE_COUNT: wide_cnt_q <= cfg.data[WC_W-1:0];
				CFG_CONTROL_WIDTH: ctrl_w_q <= $signed(cfg.data[CW_W-1:0]);
				default: ;
			endcase
		end
	end

	// counts saturate at the table depth
	always_comb begin
		zt_cnt = (32'(zero_cnt_q) > ZT_DEPTH) ? CNT_W'(ZT_DEPTH) : CNT_W'(zero_cnt_q);
		wt_cnt = (32'(wide_cnt_q) > WT_DEPTH) ? CNT_W'(WT_DEPTH) : CNT_W'(wide_cnt_q);
	end

	// table loads go straight to the rams; searches never run while idle
	assign acc = item.valid && item.ready;
	assign zt_we = acc && item.op == OP_LOAD_ZERO && 32'(item.entry_index) < ZT_DEPTH;
	assign wt_we = acc && item.op == OP_LOAD_WIDE && 32'(item.entry_index) < WT_DEPTH;

	ucwc_ram #(.DEPTH(ZT_DEPTH), .WIDTH(ENT_W)) u_zero_ram (
		.clk   (clk),
		.we    (zt_we),
		.waddr (ZT_AW'(item.entry_index)),
		.wdata ({item.range_first, item.range_last}),
		.raddr (z_addr[ZT_AW-1:0]),
		.rdata (z_data)
	);

	ucwc_ram #(.DEPTH(WT_DEPTH), .WIDTH(ENT_W)) u_wide_ram (
		.clk   (clk),
		.we    (wt_we),
		.waddr (WT_AW'(item.entry_index)),
		.wdata ({item.range_first, item.range_last}),
		.raddr (w_addr[WT_AW-1:0]),
		.rdata (w_data)
	);

	// search engines, started together
	always_comb begin
		zreq.start = start;
		zreq.cnt = zt_cnt;
		zreq.cp = cp_q;
		wreq.start = start;
		wreq.cnt = wt_cnt;
		wreq.cp = cp_q;
	end

	ucwc_search u_zero_srch (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (zreq),
		.rd_data (z_data),
		.rd_addr (z_addr),
		.res     (zres)
	);

	ucwc_search u_wide_srch (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (wreq),
		.rd_data (w_data),
		.rd_addr (w_addr),
		.res     (wres)
	);

	// classify transaction payload
	always_ff @(posedge clk) begin
		if (acc && item.op == OP_CLASSIFY) begin
			cp_q <= item.code_point;
			eos_q <= item.end_of_string;
			if (fixed_zero(item.code_point)) begin
				cls_q <= CL_FIXED_ZERO;
			end else if (is_ctrl(item.code_point)) begin
				cls_q <= CL_CONTROL;
			end else begin
				cls_q <= CL_SEARCH;
			end
		end
	end

	// collect search completions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			z_seen_q <= 1'b0;
			w_seen_q <= 1'b0;
			z_hit_q <= 1'b0;
			w_hit_q <= 1'b0;
		end else if (start) begin
			z_seen_q <= 1'b0;
			w_seen_q <= 1'b0;
		end else begin
			if (zres.done) begin
				z_seen_q <= 1'b1;
				z_hit_q <= zres.hit;
			end
			if (wres.done) begin
				w_seen_q <= 1'b1;
				w_hit_q <= wres.hit;
			end
		end
	end

	assign z_fin = z_seen_q || zres.done;
	assign w_fin = w_seen_q || wres.done;
	assign z_hit = z_seen_q ? z_hit_q : zres.hit;
	assign w_hit = w_seen_q ? w_hit_q : wres.hit;
	assign slot_free = !out_valid_q || result.ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			TS_IDLE: begin
				if (acc && item.op == OP_CLASSIFY) begin
					state_d = TS_START;
				end
			end
			TS_START: state_d = TS_WAIT;
			TS_WAIT: begin
				if (z_fin && w_fin && slot_free) begin
					state_d = TS_IDLE;
				end
			end
			default: state_d = TS_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		item.ready = 1'b0;
		start = 1'b0;
		finish = 1'b0;
		unique case (state_q)
			TS_IDLE: item.ready = 1'b1;
			TS_START: start = 1'b1;
			TS_WAIT: finish = z_fin && w_fin && slot_free;
			default: ;
		endcase
	end

	// width selection and saturating string sum
	always_comb begin
		case (cls_q)
			CL_FIXED_ZERO: w = '0;
			CL_CONTROL: w = ctrl_w_q;
			default: begin
				if (z_hit) begin
					w = 3'sd0;
				end else if (w_hit) begin
					w = 3'sd2;
				end else begin
					w = 3'sd1;
				end
			end
		endcase
		inv_new = invalid_q || w[CW_W-1];
		sum_ext = {1'b0, width_sum_q} + (SUM_W+1)'(w[CW_W-2:0]);
		if (w[CW_W-1]) begin
			sum_new = width_sum_q;
		end else if (sum_ext[SUM_W]) begin
			sum_new = '1;
		end else begin
			sum_new = sum_ext[SUM_W-1:0];
		end
	end

	// control state and string accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= TS_IDLE;
			out_valid_q <= 1'b0;
			width_sum_q <= '0;
			invalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (finish) begin
				out_valid_q <= 1'b1;
				width_sum_q <= eos_q ? '0 : sum_new;
				invalid_q <= eos_q ? 1'b0 : inv_new;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (finish) begin
			out_w_q <= w;
			out_ctrl_q <= cls_q == CL_CONTROL;
			out_sum_q <= sum_new;
			out_inv_q <= inv_new;
			out_done_q <= eos_q;
		end
	end

	assign result.valid = out_valid_q;
	assign result.char_width = out_w_q;
	assign result.is_control = out_ctrl_q;
	assign result.string_width = out_sum_q;
	assign result.string_invalid = out_inv_q;
	assign result.string_done = out_done_q;

	`UCWC_ASSERT_SAME(a_load_idle, zt_we || wt_we, state_q == TS_IDLE, "table write during search")
	`UCWC_ASSERT_NEXT(a_result_loaded, finish, result.valid, "finished item gave no result")
	`UCWC_ASSERT_NEXT(a_string_clear, finish && eos_q, width_sum_q == '0 && !invalid_q, "string state not cleared")

endmodule

`default_nettype wire

@@ dv/tb_unicode_char_width_classifier_core.sv @@
// self-checking testbench for the terminal column width classifier core
module tb_unicode_char_width_classifier_core;
	import ucwc_pkg::*;

	// codes the package leaves unnamed
	localparam logic [OP_W-1:0]   OP_UNUSED = 2'd3;
	localparam logic [CFG_AW-1:0] CFG_SPARE = 2'd3;
	localparam int NUM_SPECIAL = 20;
	localparam int DRAIN_CYCLES = 24;
	localparam int MAX_PRINTED = 100;

	typedef struct packed {
		logic signed [CW_W-1:0] char_width;
		logic                   is_control;
		logic [SUM_W-1:0]       string_width;
		logic                   string_invalid;
		logic                   string_done;
	} width_result_t;

	logic clk = 1'b0;
	logic arst_n;

	ucwc_in_if  item_if ();
	ucwc_out_if res_if ();
	ucwc_cfg_if cfg_if ();

	unicode_char_width_classifier_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_if),
		.result (res_if),
		.cfg    (cfg_if)
	);

	// shadow copy of tables, registers and string state
	logic [CP_W-1:0] zt_first [ZT_DEPTH];
	logic [CP_W-1:0] zt_last  [ZT_DEPTH];
	logic [CP_W-1:0] wt_first [WT_DEPTH];
	logic [CP_W-1:0] wt_last  [WT_DEPTH];
	int   zero_cnt = 0;
	int   wide_cnt = 0;
	int   ctrl_w = -1;
	int   run_sum = 0;
	logic run_invalid = 1'b0;

	width_result_t expected_widths [$];
	int mismatches = 0;

	// pacing of both sides
	bit   pace_on = 1'b0;
	bit   stall_on = 1'b0;
	int   burst_left = 0;
	int   hold_req = 0;
	int   hold_left = 0;
	logic [31:0] stall_pat = '1;
	logic [4:0]  pat_pos = '0;

	logic [CP_W-1:0] special_cps [NUM_SPECIAL] = '{
		21'h000000, CP_CGJ, CP_ZWSP, 21'h00200D, CP_RLM, CP_LSEP, CP_PSEP, CP_LRE,
		CP_RLO, CP_WJ, CP_ISEP, 21'h00001F, CP_SPACE, CP_DEL, 21'h00009F, CP_NBSP,
		21'h00202F, 21'h002064, 21'h10FFFF, 21'h1FFFFF
	};

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// watchdog
	initial begin
		#16_000_000;
		$display("FAIL unicode_char_width_classifier_core");
		$finish;
	end

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatches < MAX_PRINTED)
			$display("mismatch on %s: got %0h, expected %0h", field, got, want);
		mismatches++;
	endtask

	// number of table entries a search may visit
	function automatic int eff_count(input bit zero_side);
		if (zero_side)
			return (zero_cnt > ZT_DEPTH) ? ZT_DEPTH : zero_cnt;
		return (wide_cnt > WT_DEPTH) ? WT_DEPTH : wide_cnt;
	endfunction

	// binary search over the shadow table, with quick reject below entry 0
	function automatic bit interval_hit(input bit zero_side, input logic [CP_W-1:0] cp);
		int lo_i, hi_i, mid, n;
		logic [CP_W-1:0] f, l;
		n = eff_count(zero_side);
		if (n == 0)
			return 1'b0;
		f = zero_side ? zt_first[0] : wt_first[0];
		if (cp < f)
			return 1'b0;
		lo_i = 0;
		hi_i = n - 1;
		while (hi_i >= lo_i) begin
			mid = (lo_i + hi_i) / 2;
			if (zero_side) begin
				f = zt_first[mid];
				l = zt_last[mid];
			end else begin
				f = wt_first[mid];
				l = wt_last[mid];
			end
			if (l < cp)
				lo_i = mid + 1;
			else if (f > cp)
				hi_i = mid - 1;
			else
				return 1'b1;
		end
		return 1'b0;
	endfunction

	// column width of one code point and the running string state
	function automatic width_result_t predict_width(input logic [CP_W-1:0] cp, input logic eos);
		width_result_t r;
		int   w;
		logic ctl;
		ctl = 1'b0;
		// nul and the format characters that never take a column
		if (cp == 21'h0 || cp == CP_CGJ || (cp >= CP_ZWSP && cp <= CP_RLM) ||
				(cp >= CP_LSEP && cp <= CP_RLO) || (cp >= CP_WJ && cp <= CP_ISEP)) begin
			w = 0;
		end else if (cp < CP_SPACE || (cp >= CP_DEL && cp < CP_NBSP)) begin
			ctl = 1'b1;
			w = ctrl_w;
		end else if (interval_hit(1'b1, cp)) begin
			w = 0;
		end else if (interval_hit(1'b0, cp)) begin
			w = 2;
		end else begin
			w = 1;
		end
		if (w < 0) begin
			run_invalid = 1'b1;
		end else begin
			run_sum = run_sum + w;
			if (run_sum > 65535)
				run_sum = 65535;
		end
		r.char_width = w[CW_W-1:0];
		r.is_control = ctl;
		r.string_width = run_sum[SUM_W-1:0];
		r.string_invalid = run_invalid;
		r.string_done = eos;
		if (eos) begin
			run_sum = 0;
			run_invalid = 1'b0;
		end
		return r;
	endfunction

	// offer one transaction on the item channel, called at a falling edge
	task automatic send_item(input logic [OP_W-1:0] op, input logic [EIDX_W-1:0] idx,
			input logic [CP_W-1:0] first, input logic [CP_W-1:0] last,
			input logic [CP_W-1:0] cp, input logic eos);
		int gap;
		if (pace_on) begin
			if (burst_left == 0) begin
				gap = $urandom_range(0, 7);
				if (gap != 0) begin
					item_if.valid = 1'b0;
					repeat (gap) @(negedge clk);
				end
				burst_left = $urandom_range(1, 16);
			end
			burst_left--;
		end
		item_if.valid = 1'b1;
		item_if.op = op;
		item_if.entry_index = idx;
		item_if.range_first = first;
		item_if.range_last = last;
		item_if.code_point = cp;
		item_if.end_of_string = eos;
		do @(posedge clk); while (!item_if.ready);
		case (op)
			OP_CLASSIFY: expected_widths.push_back(predict_width(cp, eos));
			OP_LOAD_ZERO: begin
				zt_first[idx] = first;
				zt_last[idx] = last;
			end
			OP_LOAD_WIDE: begin
				if (idx < WT_DEPTH) begin
					wt_first[idx] = first;
					wt_last[idx] = last;
				end
			end
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic classify(input logic [CP_W-1:0] cp, input logic eos);
		send_item(OP_CLASSIFY, $urandom, $urandom, $urandom, cp, eos);
	endtask

	// register write, only while the block is idle
	task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] data);
		cfg_if.valid = 1'b1;
		cfg_if.index = idx;
		cfg_if.data = data;
		do @(posedge clk); while (!cfg_if.ready);
		case (idx)
			CFG_ZERO_COUNT:    zero_cnt = int'(data);
			CFG_WIDE_COUNT:    wide_cnt = int'(data[WC_W-1:0]);
			CFG_CONTROL_WIDTH: ctrl_w = int'($signed(data[CW_W-1:0]));
			default: ;
		endcase
		@(negedge clk);
		cfg_if.valid = 1'b0;
	endtask

	task automatic apply_setting(input int zc, input int wc, input int cw);
		write_reg(CFG_ZERO_COUNT, CFG_DW'(zc));
		write_reg(CFG_WIDE_COUNT, CFG_DW'(wc));
		write_reg(CFG_CONTROL_WIDTH, CFG_DW'(cw));
	endtask

	// stop offering, wait for every result, then let trailing loads finish
	task automatic settle();
		item_if.valid = 1'b0;
		while (expected_widths.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// fill table slots 0..n-1, ascending and disjoint or arbitrary
	task automatic load_table(input bit zero_side, input int n, input bit sorted);
		int step;
		logic [CP_W-1:0] f, l;
		step = 'h110000 / ((n > 0) ? n : 1);
		for (int i = 0; i < n; i++) begin
			if (sorted) begin
				f = i * step + $urandom_range(0, step / 2);
				l = f + $urandom_range(0, step / 2 - 1);
			end else begin
				f = $urandom;
				l = $urandom_range(0, 1) ? f + $urandom_range(0, 4096) : $urandom;
			end
			send_item(zero_side ? OP_LOAD_ZERO : OP_LOAD_WIDE, EIDX_W'(i), f, l, $urandom,
				$urandom);
		end
	endtask

	// code point aimed at table hits, interval edges, specials or anywhere
	function automatic logic [CP_W-1:0] pick_cp();
		int k, ez, ew;
		ez = eff_count(1'b1);
		ew = eff_count(1'b0);
		case ($urandom_range(0, 9))
			0, 1, 2: begin
				if (ez > 0) begin
					k = $urandom_range(0, ez - 1);
					return $urandom_range(zt_first[k], zt_last[k]);
				end
			end
			3, 4, 5: begin
				if (ew > 0) begin
					k = $urandom_range(0, ew - 1);
					return $urandom_range(wt_first[k], wt_last[k]);
				end
			end
			6: begin
				if (ez > 0 && $urandom_range(0, 1)) begin
					k = $urandom_range(0, ez - 1);
					return $urandom_range(0, 1) ? zt_first[k] - 1'b1 : zt_last[k] + 1'b1;
				end
				if (ew > 0) begin
					k = $urandom_range(0, ew - 1);
					return $urandom_range(0, 1) ? wt_first[k] - 1'b1 : wt_last[k] + 1'b1;
				end
			end
			7: return special_cps[$urandom_range(0, NUM_SPECIAL - 1)];
			default: ;
		endcase
		return ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(32, 'h10FFFF);
	endfunction

	task automatic classify_burst(input int n);
		for (int i = 0; i < n; i++)
			classify(pick_cp(), $urandom_range(0, 7) == 0);
	endtask

	// nul, format characters, control bounds and code point extremes, empty tables
	task automatic test_fixed_widths();
		for (int i = 0; i < NUM_SPECIAL; i++)
			classify(special_cps[i], i == 10 || i == NUM_SPECIAL - 1);
		send_item(OP_UNUSED, '1, '1, '1, 21'h000041, 1'b1);
		settle();
	endtask

	// small hand-built tables: quick reject, interval ends, ignored wide slot
	task automatic test_table_lookup();
		send_item(OP_LOAD_ZERO, 9'd0, 21'h000300, 21'h00036F, '0, 1'b0);
		send_item(OP_LOAD_ZERO, 9'd1, 21'h000483, 21'h000489, '0, 1'b0);
		send_item(OP_LOAD_ZERO, 9'd2, 21'h000591, 21'h0005BD, '0, 1'b0);
		send_item(OP_LOAD_WIDE, 9'd0, 21'h001100, 21'h00115F, '0, 1'b0);
		send_item(OP_LOAD_WIDE, 9'd1, 21'h002E80, 21'h00303E, '0, 1'b0);
		send_item(OP_LOAD_WIDE, 9'd2, 21'h00AC00, 21'h00D7A3, '0, 1'b0);
		send_item(OP_LOAD_WIDE, 9'd3, 21'h01F300, 21'h01F64F, '0, 1'b0);
		send_item(OP_LOAD_WIDE, 9'd300, 21'h000041, 21'h00005A, '0, 1'b0);
		settle();
		apply_setting(3, 4, 2);
		classify(21'h0002FF, 1'b0);
		classify(21'h000300, 1'b0);
		classify(21'h00036F, 1'b0);
		classify(21'h000370, 1'b0);
		classify(21'h000489, 1'b0);
		classify(21'h001100, 1'b0);
		classify(21'h00D7A3, 1'b0);
		classify(21'h00D7A4, 1'b0);
		classify(21'h01F64F, 1'b0);
		classify(21'h000041, 1'b0);
		classify(21'h000005, 1'b1);
		settle();
	endtask

	// full wide table, then wide counts past the depth, at the depth and tiny
	task automatic test_register_sweep();
		load_table(1'b1, 32, 1'b1);
		load_table(1'b0, WT_DEPTH, 1'b1);
		settle();
		apply_setting(32, 1023, -4);
		write_reg(CFG_SPARE, '1);
		classify_burst(16);
		settle();
		apply_setting(32, 256, 3);
		classify_burst(16);
		settle();
		apply_setting(1, 0, 0);
		classify_burst(12);
		settle();
		apply_setting(0, 1, 1);
		classify_burst(12);
		settle();
	endtask

	// long receiver hold-off while items keep coming
	task automatic test_backpressure();
		apply_setting(32, 32, -1);
		pace_on = 1'b0;
		hold_req = 400;
		classify_burst(40);
		pace_on = 1'b1;
		settle();
	endtask

	// a string of width-3 controls adds up, then fresh strings after its end
	task automatic test_control_sum();
		pace_on = 1'b0;
		stall_on = 1'b0;
		apply_setting(0, 0, 3);
		for (int i = 0; i < 24; i++)
			classify($urandom_range(0, 1) ? $urandom_range(1, 31) : $urandom_range('h7F, 'h9F),
				1'b0);
		classify(21'h004E00, 1'b0);
		classify(CP_SPACE, 1'b1);
		classify(21'h000001, 1'b1);
		settle();
		pace_on = 1'b1;
		stall_on = 1'b1;
	endtask

	// phases of fresh tables and settings, classify traffic mixed with loads and noise
	task automatic test_random_traffic();
		int nz, nw, cw, pick;
		bit sorted;
		for (int ph = 0; ph < 3; ph++) begin
			pace_on = $urandom_range(0, 3) != 0;
			stall_on = $urandom_range(0, 3) != 0;
			nz = $urandom_range(0, 10);
			nw = $urandom_range(0, 10);
			sorted = $urandom_range(0, 3) != 0;
			load_table(1'b1, nz, sorted);
			load_table(1'b0, nw, sorted);
			settle();
			cw = int'($urandom_range(0, 7)) - 4;
			apply_setting(nz, nw, cw);
			for (int i = 0; i < 16; i++) begin
				pick = $urandom_range(0, 19);
				if (pick == 0)
					send_item(OP_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom);
				else if (pick == 1)
					send_item(OP_LOAD_ZERO, $urandom_range(nz, ZT_DEPTH - 1), $urandom, $urandom,
						$urandom, $urandom);
				else if (pick == 2)
					send_item(OP_LOAD_WIDE, $urandom_range(nw, ZT_DEPTH - 1), $urandom, $urandom,
						$urandom, $urandom);
				else
					classify(pick_cp(), $urandom_range(0, 7) == 0);
			end
			settle();
		end
	endtask

	// receiver: pattern stalls, or a counted hold-off when requested
	always @(negedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left != 0) begin
			res_if.ready = 1'b0;
			hold_left--;
		end else if (!stall_on) begin
			res_if.ready = 1'b1;
		end else begin
			if (pat_pos == '0)
				stall_pat = $urandom_range(0, 1) ? ($urandom | $urandom) : $urandom;
			res_if.ready = stall_pat[pat_pos];
			pat_pos = pat_pos + 1'b1;
		end
	end

	// compare each result transaction with the oldest expected one
	always @(posedge clk) begin
		width_result_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (expected_widths.size() == 0) begin
				report_mismatch("unexpected result", res_if.string_width, '0);
			end else begin
				want = expected_widths.pop_front();
				if (res_if.char_width !== want.char_width)
					report_mismatch("char_width", res_if.char_width, want.char_width);
				if (res_if.is_control !== want.is_control)
					report_mismatch("is_control", res_if.is_control, want.is_control);
				if (res_if.string_width !== want.string_width)
					report_mismatch("string_width", res_if.string_width, want.string_width);
				if (res_if.string_invalid !== want.string_invalid)
					report_mismatch("string_invalid", res_if.string_invalid,
						want.string_invalid);
				if (res_if.string_done !== want.string_done)
					report_mismatch("string_done", res_if.string_done, want.string_done);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		item_if.valid = 1'b0;
		item_if.op = OP_CLASSIFY;
		item_if.entry_index = '0;
		item_if.range_first = '0;
		item_if.range_last = '0;
		item_if.code_point = '0;
		item_if.end_of_string = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.index = CFG_ZERO_COUNT;
		cfg_if.data = '0;
		res_if.ready = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		pace_on = 1'b1;
		stall_on = 1'b1;
		test_fixed_widths();
		test_table_lookup();
		test_register_sweep();
		test_backpressure();
		test_control_sum();
		test_random_traffic();
		settle();
		if (mismatches == 0)
			$display("PASS unicode_char_width_classifier_core");
		else
			$display("FAIL unicode_char_width_classifier_core");
		$finish;
	end

endmodule
